FILE: rtl/rgb_conv3x3_clamp_top_macros.svh
// Assertion macros for RTL that checks its own logic; rgb_conv3x3_clamp_top includes them.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef RGB_CONV3X3_CLAMP_TOP_MACROS_SVH
`define RGB_CONV3X3_CLAMP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rcc_pkg.sv
package rcc_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COEF_BITS = 16;

	localparam int TAP_W = 16;
	localparam int TAP_BITS = (COEF_BITS >= TAP_W) ? TAP_W : COEF_BITS;
	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CFG_WIDTH_BITS = 12;
	localparam int CFG_HEIGHT_BITS = 16;
	localparam int EW = (COL_W + 1 > CFG_WIDTH_BITS) ? COL_W + 1 : CFG_WIDTH_BITS;
	localparam int ROW_W = 16;
	localparam int PROD_W = TAP_W + CH_W + 1;
	localparam int SUM_W = PROD_W + 4;
	localparam int FRAC_SHIFT = 8;
	localparam int CH_MAX = 255;

	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

	localparam logic [CFG_DATA_W-1:0] COEF_TOP_RESET = 48'd0;
	localparam logic [CFG_DATA_W-1:0] COEF_MID_RESET = 48'd65536;
	localparam logic [CFG_DATA_W-1:0] COEF_BOTTOM_RESET = 48'd0;
	localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = 12'd640;
	localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

	typedef struct packed {
		logic emit;
		logic last;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} tap_ctl_t;

	function automatic logic signed [TAP_W-1:0] tap_of(input logic [CFG_DATA_W-1:0] coef_row,
			input logic [1:0] k);
		logic [TAP_W-1:0] slot;
		logic signed [TAP_BITS-1:0] v;
		slot = coef_row[TAP_W*k +: TAP_W];
		v = slot[TAP_BITS-1:0];
		return TAP_W'(v);
	endfunction

	function automatic logic [CH_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] q;
		q = s >>> FRAC_SHIFT;
		if (s < 0) begin
			return '0;
		end else if (q > $signed(SUM_W'(CH_MAX))) begin
			return CH_W'(CH_MAX);
		end
		return q[CH_W-1:0];
	endfunction

endpackage

FILE: rtl/rcc_ram.sv
module rcc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rgb_conv3x3_clamp_top.sv
// Accepts one item per cycle unless the output skid register is full or the line stores are
// being cleared; a pixel's result passes the first stage, the window, the product and output
// registers after the input item that completes its neighborhood. The rate is set by the
// single read and write port of each line store. After reset both line stores are cleared at
// all 2048 addresses with no input taken; configuration resets to center tap 1/256, 640x480.
`include "rgb_conv3x3_clamp_top_macros.svh"

module rgb_conv3x3_clamp_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [rcc_pkg::PIX_W-1:0]        s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                             s_axis_tuser,  // req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [rcc_pkg::PIX_W-1:0]        m_axis_tdata,  // out_red, out_green, out_blue
	output logic                             m_axis_tlast
);
	import rcc_pkg::*;

	logic [CFG_DATA_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [CFG_WIDTH_BITS-1:0] width_q;
	logic [CFG_HEIGHT_BITS-1:0] height_q;
	logic [EW-1:0] eff_w;
	logic [ROW_W:0] eff_h;

	logic clear_busy_q;
	logic [COL_W-1:0] clear_addr_q;

	logic en, acc;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [EW-1:0] in_col_inc, out_col_inc;
	logic [ROW_W:0] out_row_inc;
	logic in_wrap, emit_w, last_w, out_right, out_bot;
	logic [PIX_W-1:0] pix_w;
	tap_ctl_t ctl_w;

	logic valid_s1, fwd_s1;
	logic [PIX_W-1:0] pix_s1, fwd_up_s1, fwd_lo_s1;
	logic [COL_W-1:0] col_s1;
	tap_ctl_t ctl_s1;
	logic [PIX_W-1:0] up_rdata, lo_rdata, up_s1, lo_s1;
	logic ram_we;
	logic [COL_W-1:0] ram_waddr;
	logic [PIX_W-1:0] up_wdata, lo_wdata;

	logic [PIX_W-1:0] win_q [3][3];
	logic valid_s2;
	tap_ctl_t ctl_s2;
	logic [CFG_DATA_W-1:0] coef_rows [3];
	logic signed [PROD_W-1:0] prod_w [3][3][3];

	logic valid_s3;
	tap_ctl_t ctl_s3;
	logic signed [PROD_W-1:0] prod_s3 [3][3][3];
	logic [PIX_W-1:0] res_data;
	logic res_valid;

	logic out_valid_q, out_last_q, skid_valid_q, skid_last_q, take;
	logic [PIX_W-1:0] out_data_q, skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= COEF_TOP_RESET;
			coef_mid_q <= COEF_MID_RESET;
			coef_bot_q <= COEF_BOTTOM_RESET;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COEF_TOP: coef_top_q <= cfg_wdata;
				CFG_COEF_MID: coef_mid_q <= cfg_wdata;
				CFG_COEF_BOTTOM: coef_bot_q <= cfg_wdata;
				CFG_IMAGE_WIDTH: width_q <= cfg_wdata[CFG_WIDTH_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_wdata[CFG_HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
		eff_h = (height_q == '0) ? (ROW_W+1)'(1) : {1'b0, height_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clear_addr_q <= '0;
		end else if (clear_busy_q) begin
			clear_addr_q <= clear_addr_q + COL_W'(1);
			if (clear_addr_q == COL_W'(MAX_WIDTH - 1)) begin
				clear_busy_q <= 1'b0;
			end
		end
	end

	assign en = !skid_valid_q;
	assign s_axis_tready = en && !clear_busy_q;
	assign acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_col_inc = EW'(in_col_q) + EW'(1);
		in_wrap = in_col_inc >= eff_w;
		emit_w = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		out_col_inc = EW'(out_col_q) + EW'(1);
		out_right = out_col_inc >= eff_w;
		out_row_inc = {1'b0, out_row_q} + (ROW_W+1)'(1);
		out_bot = out_row_inc >= eff_h;
		last_w = out_bot && out_right;
		pix_w = s_axis_tuser ? '0 : s_axis_tdata;
		ctl_w.emit = emit_w;
		ctl_w.last = last_w;
		ctl_w.top = (out_row_q == '0);
		ctl_w.bottom = out_bot;
		ctl_w.left = (out_col_q == '0);
		ctl_w.right = out_right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (emit_w && last_w) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (in_row_q != {ROW_W{1'b1}}) begin
						in_row_q <= in_row_q + ROW_W'(1);
					end
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (emit_w) begin
					if (out_right) begin
						out_col_q <= '0;
						out_row_q <= out_row_inc[ROW_W-1:0];
					end else begin
						out_col_q <= out_col_inc[COL_W-1:0];
					end
				end
			end
		end
	end

	assign up_s1 = fwd_s1 ? fwd_up_s1 : up_rdata;
	assign lo_s1 = fwd_s1 ? fwd_lo_s1 : lo_rdata;
	assign ram_we = clear_busy_q || (valid_s1 && en);
	assign ram_waddr = clear_busy_q ? clear_addr_q : col_s1;
	assign up_wdata = clear_busy_q ? '0 : lo_s1;
	assign lo_wdata = clear_busy_q ? '0 : pix_s1;

	rcc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) line_store_upper (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(up_wdata),
		.re(acc),
		.raddr(in_col_q),
		.rdata(up_rdata)
	);

	rcc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) line_store_lower (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(lo_wdata),
		.re(acc),
		.raddr(in_col_q),
		.rdata(lo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// A same-column item right behind reads the store on the cycle the one ahead writes it.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= pix_w;
			col_s1 <= in_col_q;
			ctl_s1 <= ctl_w;
			fwd_s1 <= valid_s1 && (col_s1 == in_col_q);
			fwd_up_s1 <= lo_s1;
			fwd_lo_s1 <= pix_s1;
		end
		if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			prod_s3 <= prod_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (valid_s1 && en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_s1;
			win_q[1][2] <= lo_s1;
			win_q[2][2] <= pix_s1;
		end
	end

	assign coef_rows[0] = coef_top_q;
	assign coef_rows[1] = coef_mid_q;
	assign coef_rows[2] = coef_bot_q;

	always_comb begin
		logic signed [TAP_W-1:0] tap;
		logic masked;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				masked = ((r == 0) && ctl_s2.top) || ((r == 2) && ctl_s2.bottom) ||
					((c == 0) && ctl_s2.left) || ((c == 2) && ctl_s2.right);
				tap = masked ? '0 : tap_of(coef_rows[r], 2'(c));
				for (int ch = 0; ch < 3; ch++) begin
					prod_w[r][c][ch] = PROD_W'(tap) *
						PROD_W'($signed({1'b0, win_q[r][c][CH_W*ch +: CH_W]}));
				end
			end
		end
	end

	always_comb begin
		logic signed [SUM_W-1:0] acc_sum;
		for (int ch = 0; ch < 3; ch++) begin
			acc_sum = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					acc_sum = acc_sum + SUM_W'(prod_s3[r][c][ch]);
				end
			end
			res_data[CH_W*ch +: CH_W] = clamp_ch(acc_sum);
		end
	end

	assign res_valid = valid_s3 && ctl_s3.emit && en;
	assign take = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end else if (res_valid) begin
				out_data_q <= res_data;
				out_last_q <= ctl_s3.last;
			end
		end else if (res_valid) begin
			skid_data_q <= res_data;
			skid_last_q <= ctl_s3.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

	`RCC_ASSERT_IMP(a_no_transfer_in_clear, clear_busy_q, !s_axis_tready, "transfer taken during line store clear")
	`RCC_ASSERT_IMP(a_skid_behind_output, skid_valid_q, out_valid_q, "skid holds a result while the output register is empty")
	`RCC_ASSERT_NEXT(a_frame_end_rewinds, acc && emit_w && last_w, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "position counters not cleared after frame end")
	`RCC_ASSERT_NEXT(a_transfer_enters_s1, acc, valid_s1, "accepted item missing from first stage")

endmodule

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rcc_pkg::*;

	localparam int QUIET_LIMIT = 6000;
	localparam int DRAIN_PAD = 8;
	localparam int RAND_ITEMS = 1750;

	typedef enum logic {REQ_PIXEL = 1'b0, REQ_FLUSH = 1'b1} req_e;
	typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_e;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		req_e kind;
		rgb_t pix;
	} stim_t;

	typedef struct packed {
		logic frame_end;
		rgb_t pix;
	} filt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [PIX_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [PIX_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	rgb_conv3x3_clamp_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Shadow configuration and filter state.
	logic [CFG_DATA_W-1:0] coef_rows [3];
	logic [CFG_WIDTH_BITS-1:0] img_w_reg;
	logic [CFG_HEIGHT_BITS-1:0] img_h_reg;
	rgb_t row_prev2 [MAX_WIDTH];
	rgb_t row_prev1 [MAX_WIDTH];
	rgb_t nbhd [3][3];
	int unsigned feed_col, feed_row, emit_col, emit_row;

	stim_t stim_q[$];
	filt_t filtered_q[$];
	int unsigned items_queued, items_taken, fail_cnt, quiet_cycles;
	int in_gap, out_gap;
	bit in_fire, out_fire;
	idle_e idle_mode = IDLE_NONE;

	function automatic int unsigned eff_width();
		if (img_w_reg == 0) begin
			return 1;
		end else if (img_w_reg > MAX_WIDTH) begin
			return MAX_WIDTH;
		end
		return img_w_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (img_h_reg == 0) ? 1 : img_h_reg;
	endfunction

	function automatic logic [CH_W-1:0] clamp_to_byte(input longint s);
		if (s < 0) begin
			return '0;
		end else if ((s >>> FRAC_SHIFT) > CH_MAX) begin
			return CH_W'(CH_MAX);
		end
		return CH_W'(s >>> FRAC_SHIFT);
	endfunction

	function automatic void filter_pixel(input req_e kind, input rgb_t in_pix);
		int unsigned w, h;
		rgb_t pix, above2, above1, p;
		bit emit, last;
		longint acc_r, acc_g, acc_b, tap;
		filt_t res;
		pix = (kind == REQ_PIXEL) ? in_pix : '0;
		w = eff_width();
		h = eff_height();
		above2 = row_prev2[feed_col];
		above1 = row_prev1[feed_col];
		row_prev2[feed_col] = above1;
		row_prev1[feed_col] = pix;
		for (int r = 0; r < 3; r++) begin
			nbhd[r][0] = nbhd[r][1];
			nbhd[r][1] = nbhd[r][2];
		end
		nbhd[0][2] = above2;
		nbhd[1][2] = above1;
		nbhd[2][2] = pix;
		emit = (feed_row >= 2) || (feed_row == 1 && feed_col >= 1);
		if (feed_col + 1 >= w) begin
			feed_col = 0;
			if (feed_row < 65535) feed_row++;
		end else begin
			feed_col++;
		end
		if (!emit) return;

		acc_r = 0;
		acc_g = 0;
		acc_b = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if ((r == 0 && emit_row == 0) || (r == 2 && emit_row + 1 >= h) ||
						(c == 0 && emit_col == 0) || (c == 2 && emit_col + 1 >= w))
					continue;
				tap = longint'($signed(coef_rows[r][TAP_W*c +: TAP_W]));
				p = nbhd[r][c];
				acc_r += tap * longint'(p.red);
				acc_g += tap * longint'(p.green);
				acc_b += tap * longint'(p.blue);
			end
		end
		last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
		res.pix.red = clamp_to_byte(acc_r);
		res.pix.green = clamp_to_byte(acc_g);
		res.pix.blue = clamp_to_byte(acc_b);
		res.frame_end = last;
		filtered_q.push_back(res);

		if (last) begin
			feed_col = 0;
			feed_row = 0;
			emit_col = 0;
			emit_row = 0;
		end else if (emit_col + 1 >= w) begin
			emit_col = 0;
			emit_row = (emit_row + 1) % 65536;
		end else begin
			emit_col++;
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	function automatic int idle_draw();
		case (idle_mode)
			IDLE_FULL: return $urandom_range(0, 17);
			IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
			default: return 0;
		endcase
	endfunction

	// Sampling at the rising edge: prediction, checking and the watchdog.
	always @(posedge clk) begin
		rgb_t got;
		filt_t want;
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		out_fire = arst_n && m_axis_tvalid && m_axis_tready;
		if (in_fire) begin
			filter_pixel(req_e'(s_axis_tuser), rgb_t'(s_axis_tdata));
			items_taken++;
		end
		if (out_fire) begin
			got = rgb_t'(m_axis_tdata);
			if (filtered_q.size() == 0) begin
				$display("%0t: result with no expectation pending, expected none, actual %h/%b",
					$time, m_axis_tdata, m_axis_tlast);
				fail_cnt++;
			end else begin
				want = filtered_q.pop_front();
				check_field("out_red", want.pix.red, got.red);
				check_field("out_green", want.pix.green, got.green);
				check_field("out_blue", want.pix.blue, got.blue);
				check_field("frame_end", want.frame_end, m_axis_tlast);
			end
		end
		quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Input driver: one transfer per queued item, with a random gap after each.
	always @(negedge clk) begin
		stim_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (in_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				in_gap--;
			end else if (stim_q.size() != 0) begin
				item = stim_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= item.pix;
				s_axis_tuser <= item.kind;
				in_gap = idle_draw();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output back-pressure: after each transfer the sink stalls for a random count.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (out_fire || !m_axis_tready) begin
			if (out_gap != 0) begin
				m_axis_tready <= 1'b0;
				out_gap--;
			end else begin
				m_axis_tready <= 1'b1;
				out_gap = idle_draw();
			end
		end
	end

	function automatic rgb_t pix_of(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		return {b, g, r};
	endfunction

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return CH_W'($urandom());
		endcase
	endfunction

	function automatic rgb_t rand_pixel();
		return pix_of(rand_chan(), rand_chan(), rand_chan());
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_coef_row(input bit is_mid);
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		case ($urandom_range(0, 3))
			0: begin
				for (int k = 0; k < 3; k++)
					v[TAP_W*k +: TAP_W] = TAP_W'($urandom_range(0, 512)) - 16'd256;
			end
			1: v = CFG_DATA_W'({$urandom(), $urandom()});
			2: v = is_mid ? COEF_MID_RESET : COEF_TOP_RESET;
			default: begin
				for (int k = 0; k < 3; k++)
					v[TAP_W*k +: TAP_W] = TAP_W'($urandom_range(0, 128)) - 16'd32;
			end
		endcase
		return v;
	endfunction

	task automatic push_item(input req_e kind, input rgb_t pix);
		stim_t item;
		item.kind = kind;
		item.pix = pix;
		stim_q.push_back(item);
		items_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			CFG_COEF_TOP, CFG_COEF_MID, CFG_COEF_BOTTOM: coef_rows[idx] = val;
			CFG_IMAGE_WIDTH: img_w_reg = val[CFG_WIDTH_BITS-1:0];
			CFG_IMAGE_HEIGHT: img_h_reg = val[CFG_HEIGHT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || filtered_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	// Sends flush items one at a time until the filter is back at the start of a frame.
	task automatic realign();
		idle_mode = IDLE_NONE;
		while (feed_col != 0 || feed_row != 0 || emit_col != 0 || emit_row != 0) begin
			push_item(REQ_FLUSH, rand_pixel());
			while (items_taken != items_queued)
				@(negedge clk);
		end
		wait_idle();
	endtask

	task automatic send_frame();
		int unsigned w, h, n_flush, n_extra;
		w = eff_width();
		h = eff_height();
		n_flush = w + 1;
		n_extra = 0;
		case ($urandom_range(0, 15))
			0: n_flush = $urandom_range(0, w);
			1: n_extra = $urandom_range(1, 3);
			default: ;
		endcase
		for (int i = 0; i < w * h; i++)
			push_item(($urandom_range(0, 31) == 0) ? REQ_FLUSH : REQ_PIXEL, rand_pixel());
		repeat (n_flush) push_item(REQ_FLUSH, rand_pixel());
		repeat (n_extra) push_item(req_e'($urandom_range(0, 1)), rand_pixel());
	endtask

	task automatic random_phase();
		logic [CFG_DATA_W-1:0] v;
		if ($urandom_range(0, 1)) write_reg(CFG_COEF_TOP, rand_coef_row(1'b0));
		if ($urandom_range(0, 1)) write_reg(CFG_COEF_MID, rand_coef_row(1'b1));
		if ($urandom_range(0, 1)) write_reg(CFG_COEF_BOTTOM, rand_coef_row(1'b0));
		if ($urandom_range(0, 1)) begin
			v = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom(), $urandom()}) : '0;
			case ($urandom_range(0, 9))
				0: v[CFG_WIDTH_BITS-1:0] = '0;
				1, 2: v[CFG_WIDTH_BITS-1:0] = CFG_WIDTH_BITS'($urandom_range(7, 40));
				default: v[CFG_WIDTH_BITS-1:0] = CFG_WIDTH_BITS'($urandom_range(1, 6));
			endcase
			write_reg(CFG_IMAGE_WIDTH, v);
		end
		if ($urandom_range(0, 1)) begin
			v = $urandom_range(0, 1) ? CFG_DATA_W'({$urandom(), $urandom()}) : '0;
			case ($urandom_range(0, 9))
				0: v[CFG_HEIGHT_BITS-1:0] = '0;
				1, 2: v[CFG_HEIGHT_BITS-1:0] = CFG_HEIGHT_BITS'($urandom_range(6, 12));
				default: v[CFG_HEIGHT_BITS-1:0] = CFG_HEIGHT_BITS'($urandom_range(1, 5));
			endcase
			write_reg(CFG_IMAGE_HEIGHT, v);
		end
		idle_mode = idle_e'($urandom_range(0, 2));
		repeat ($urandom_range(1, 3)) send_frame();
		wait_idle();
	endtask

	initial begin
		int unsigned rand_base;
		bit wide_done;
		coef_rows[0] = COEF_TOP_RESET;
		coef_rows[1] = COEF_MID_RESET;
		coef_rows[2] = COEF_BOTTOM_RESET;
		img_w_reg = WIDTH_RESET;
		img_h_reg = HEIGHT_RESET;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_prev2[i] = '0;
			row_prev1[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				nbhd[r][c] = '0;
		feed_col = 0;
		feed_row = 0;
		emit_col = 0;
		emit_row = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset kernel on a 3x3 frame: the center tap is 1/256, so every result is zero.
		idle_mode = IDLE_NONE;
		write_reg(CFG_IMAGE_WIDTH, 48'd3);
		write_reg(CFG_IMAGE_HEIGHT, 48'd3);
		push_item(REQ_PIXEL, pix_of(8'h00, 8'h00, 8'h00));
		push_item(REQ_PIXEL, pix_of(8'hFF, 8'hFF, 8'hFF));
		push_item(REQ_PIXEL, pix_of(8'hAA, 8'h55, 8'hF0));
		push_item(REQ_PIXEL, pix_of(8'h55, 8'hAA, 8'h0F));
		repeat (5) push_item(REQ_PIXEL, rand_pixel());
		repeat (4) push_item(REQ_FLUSH, rand_pixel());
		wait_idle();

		// Largest positive taps saturate high; a flush sits inside the frame.
		idle_mode = IDLE_FULL;
		write_reg(CFG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
		write_reg(CFG_COEF_MID, 48'h7FFF_7FFF_7FFF);
		write_reg(CFG_COEF_BOTTOM, 48'h7FFF_7FFF_7FFF);
		write_reg(CFG_IMAGE_WIDTH, 48'd2);
		write_reg(CFG_IMAGE_HEIGHT, 48'd2);
		push_item(REQ_PIXEL, pix_of(8'hFF, 8'hFF, 8'hFF));
		push_item(REQ_FLUSH, pix_of(8'hFF, 8'hFF, 8'hFF));
		push_item(REQ_PIXEL, pix_of(8'hFF, 8'h01, 8'h80));
		push_item(REQ_PIXEL, pix_of(8'hFF, 8'hFF, 8'hFF));
		repeat (3) push_item(REQ_FLUSH, rand_pixel());
		wait_idle();

		// Most negative taps saturate low; zero width and height act as one.
		idle_mode = IDLE_SPARSE;
		write_reg(CFG_COEF_TOP, 48'h8000_8000_8000);
		write_reg(CFG_COEF_MID, 48'h8000_8000_8000);
		write_reg(CFG_COEF_BOTTOM, 48'h8000_8000_8000);
		write_reg(CFG_IMAGE_WIDTH, 48'd0);
		write_reg(CFG_IMAGE_HEIGHT, 48'd0);
		push_item(REQ_PIXEL, pix_of(8'hFF, 8'hFF, 8'hFF));
		repeat (2) push_item(REQ_FLUSH, rand_pixel());
		wait_idle();

		rand_base = items_queued;
		wide_done = 1'b0;
		while (items_queued - rand_base < RAND_ITEMS) begin
			if (!wide_done && items_queued - rand_base >= RAND_ITEMS / 2) begin
				// Full-width rows exercise the whole depth of the line stores; the
				// geometry then shrinks in the middle of the frame.
				wide_done = 1'b1;
				realign();
				write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(MAX_WIDTH, 4095)));
				write_reg(CFG_IMAGE_HEIGHT, 48'hFFFF);
				write_reg(CFG_COEF_TOP, rand_coef_row(1'b0));
				write_reg(CFG_COEF_MID, rand_coef_row(1'b1));
				write_reg(CFG_COEF_BOTTOM, rand_coef_row(1'b0));
				idle_mode = IDLE_NONE;
				repeat (MAX_WIDTH + 40) push_item(REQ_PIXEL, rand_pixel());
				wait_idle();
				write_reg(CFG_IMAGE_WIDTH, 48'd3);
				write_reg(CFG_IMAGE_HEIGHT, 48'd2);
				realign();
			end
			random_phase();
		end
		wait_idle();
		repeat (20) @(negedge clk);
		if (fail_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
